### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the rtl; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/g4mis_pkg.sv
// ----------------------------------------------------------------------------
// g4mis_pkg
// Types, constants and helper functions for the 4-row independent set core.
// ----------------------------------------------------------------------------
package g4mis_pkg;

    localparam int ROWS  = 4;
    localparam int MASKS = 8;
    localparam int ROW_W = 32;
    localparam int SUM_W = 64;

    typedef logic signed [SUM_W-1:0] sum_t;

    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    // column masks with no vertically adjacent bits, lane k owns entry k
    localparam logic [MASKS-1:0][ROWS-1:0] COL_MASK = {
        4'd10, 4'd9, 4'd8, 4'd5, 4'd4, 4'd2, 4'd1, 4'd0
    };

    // one column beat moving between pipeline stages
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

    function automatic sum_t max64(input sum_t a, input sum_t b);
        return (a > b) ? a : b;
    endfunction

    // three-level compare tree over eight sums
    function automatic sum_t tree_max8(input sum_t v [MASKS]);
        sum_t lvl1 [4];
        sum_t lvl2 [2];
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = max64(v[2*i], v[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = max64(lvl1[2*i], lvl1[2*i+1]);
        end
        return max64(lvl2[0], lvl2[1]);
    endfunction

    // signed add clamped to the 64-bit limits
    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

### hw/rtl/g4mis_lane.sv
// ----------------------------------------------------------------------------
// g4mis_lane
// One column-mask lane: best compatible predecessor plus this column's sum.
// ----------------------------------------------------------------------------
module g4mis_lane #(
    parameter int LANE = 0
) (
    input  logic               aclk,
    input  logic               load,
    input  logic               fresh,
    input  g4mis_pkg::sum_t    state_i [g4mis_pkg::MASKS],
    input  g4mis_pkg::sum_t    vals_i  [g4mis_pkg::ROWS],
    output g4mis_pkg::sum_t    best_o
);

    localparam logic [g4mis_pkg::ROWS-1:0] MY_MASK = g4mis_pkg::COL_MASK[LANE];

    g4mis_pkg::sum_t cand [g4mis_pkg::MASKS];
    g4mis_pkg::sum_t prev;
    g4mis_pkg::sum_t col_sum;
    g4mis_pkg::sum_t best_reg;
    g4mis_pkg::sum_t best_next;

    // masks sharing a bit drop out of the predecessor max; mask 0 always fits
    always_comb begin
        for (int p = 0; p < g4mis_pkg::MASKS; p++) begin
            cand[p] = ((g4mis_pkg::COL_MASK[p] & MY_MASK) == '0)
                      ? state_i[p] : g4mis_pkg::SUM_MIN;
        end
        prev = fresh ? '0 : g4mis_pkg::tree_max8(cand);
    end

    // at most two rows are chosen, so this sum cannot overflow
    always_comb begin
        col_sum = '0;
        for (int r = 0; r < g4mis_pkg::ROWS; r++) begin
            if (MY_MASK[r]) begin
                col_sum = col_sum + vals_i[r];
            end
        end
        best_next = g4mis_pkg::sat_add(prev, col_sum);
    end

    // running best for this mask
    always_ff @(posedge aclk) begin
        if (load) begin
            best_reg <= best_next;
        end
    end

    assign best_o = best_reg;

endmodule

### hw/rtl/g4mis_merge.sv
// ----------------------------------------------------------------------------
// g4mis_merge
// Combines the non-empty lanes into a column max, folds it into the board
// total and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module g4mis_merge (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  g4mis_pkg::beat_ctl_t    lane_ctl,
    input  g4mis_pkg::sum_t         lane_best [g4mis_pkg::MASKS],
    output logic                    lane_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [63:0]             m_tdata    // [63:0] best_sum
);

    logic               v2_reg;
    logic               l2_reg;
    g4mis_pkg::sum_t    colmax_reg;
    g4mis_pkg::sum_t    colmax_next;
    g4mis_pkg::sum_t    overall_reg;
    g4mis_pkg::sum_t    acc_max;
    g4mis_pkg::sum_t    nonempty [g4mis_pkg::MASKS];
    logic               m_valid_reg;
    g4mis_pkg::sum_t    m_data_reg;
    logic               out_free;
    logic               take1;
    logic               take2;

    // handshake between stages
    assign out_free  = !m_valid_reg || m_tready;
    assign take2     = v2_reg && (!l2_reg || out_free);
    assign lane_free = !v2_reg || take2;
    assign take1     = lane_ctl.valid && lane_free;

    // max over every lane but the empty mask
    always_comb begin
        nonempty[0] = g4mis_pkg::SUM_MIN;
        for (int k = 1; k < g4mis_pkg::MASKS; k++) begin
            nonempty[k] = lane_best[k];
        end
        colmax_next = g4mis_pkg::tree_max8(nonempty);
        acc_max     = g4mis_pkg::max64(overall_reg, colmax_reg);
    end

    // column max stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            l2_reg <= 1'b0;
        end else if (take1) begin
            v2_reg <= 1'b1;
            l2_reg <= lane_ctl.last;
        end else if (take2) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take1) begin
            colmax_reg <= colmax_next;
        end
    end

    // board total, restarted after the last column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overall_reg <= g4mis_pkg::SUM_MIN;
        end else if (take2) begin
            overall_reg <= l2_reg ? g4mis_pkg::SUM_MIN : acc_max;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take2 && l2_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take2 && l2_reg) begin
            m_data_reg <= acc_max;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a result appears only when a last column leaves the column max stage
    `ASSERT_PROP(a_result_from_last, aclk, aresetn, $rose(m_valid_reg) |-> $past(v2_reg && l2_reg))
    // the total restarts after every board
    `ASSERT_PROP(a_total_restart, aclk, aresetn, (take2 && l2_reg) |=> (overall_reg == g4mis_pkg::SUM_MIN))
    // a last column never overruns a result still waiting
    `ASSERT_NEVER(a_no_overrun, aclk, aresetn, take2 && l2_reg && m_valid_reg && !m_tready)

endmodule

### hw/rtl/grid4_independent_set_max_sum_core.sv
// ----------------------------------------------------------------------------
// grid4_independent_set_max_sum_core
// Largest sum of non-adjacent cells on a 4-row board streamed by columns.
// ----------------------------------------------------------------------------
// One column enters per beat: four signed row values in s_tdata, s_tlast on
// the final column of a board. A new column is taken every clock cycle
// unless a waiting result stalls the stages; the only loop is the eight-lane
// mask update (compatible-mask max plus column sum). The board result, the
// largest sum of a non-empty set of cells with no two touching vertically or
// horizontally, leaves on m_tdata via lane, column max and output registers;
// the next board follows with no gap. Row values use their low VALUE_BITS
// bits as two's complement; running sums saturate at the 64-bit limits.
`include "assert_macros.svh"

module grid4_independent_set_max_sum_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [127:0]    s_tdata,   // [31:0] row0_value, [63:32] row1_value,
                                       // [95:64] row2_value, [127:96] row3_value
    input  logic            s_tlast,   // last_column
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata    // [63:0] best_sum
);

    logic                   v1_reg;
    logic                   l1_reg;
    logic                   fresh_reg;
    logic                   accept;
    logic                   lane_free;
    g4mis_pkg::beat_ctl_t   lane_ctl;
    g4mis_pkg::sum_t        vals  [g4mis_pkg::ROWS];
    g4mis_pkg::sum_t        state [g4mis_pkg::MASKS];

    // input handshake
    assign s_tready = !v1_reg || lane_free;
    assign accept   = s_tvalid && s_tready;

    // sign-extend the used bits of each row
    always_comb begin
        for (int r = 0; r < g4mis_pkg::ROWS; r++) begin
            vals[r] = 64'($signed(s_tdata[r*g4mis_pkg::ROW_W +: VALUE_BITS]));
        end
    end

    // lane stage occupancy and start-of-board flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            fresh_reg <= 1'b1;
        end else if (accept) begin
            v1_reg    <= 1'b1;
            l1_reg    <= s_tlast;
            fresh_reg <= s_tlast;
        end else if (lane_free) begin
            v1_reg    <= 1'b0;
        end
    end

    // one lane per column mask
    for (genvar k = 0; k < g4mis_pkg::MASKS; k++) begin : g_lane
        g4mis_lane #(
            .LANE (k)
        ) u_lane (
            .aclk    (aclk),
            .load    (accept),
            .fresh   (fresh_reg),
            .state_i (state),
            .vals_i  (vals),
            .best_o  (state[k])
        );
    end

    assign lane_ctl.valid = v1_reg;
    assign lane_ctl.last  = l1_reg;

    // column max, board total and output register
    g4mis_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_ctl  (lane_ctl),
        .lane_best (state),
        .lane_free (lane_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a board starts fresh exactly after its last column
    `ASSERT_PROP(a_fresh_follows_last, aclk, aresetn, accept |=> (fresh_reg == $past(s_tlast)))
    // a stalled lane beat is never overwritten by a new column
    `ASSERT_NEVER(a_lane_overwrite, aclk, aresetn, accept && v1_reg && !lane_free)
    // a held lane beat keeps its last flag
    `ASSERT_PROP(a_lane_hold, aclk, aresetn, (v1_reg && !lane_free) |=> (v1_reg && $stable(l1_reg)))

endmodule
